[design/sstf_disk_request_scheduler_top_macros.svh]
// Assertion macros for the scheduler
`ifndef SSTF_DISK_REQUEST_SCHEDULER_TOP_MACROS_SVH
`define SSTF_DISK_REQUEST_SCHEDULER_TOP_MACROS_SVH

// Same-cycle implication
`define SSTF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define SSTF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/sstf_pkg.sv]
package sstf_pkg;

    localparam int POOL_DEPTH = 16;
    localparam int IDX_W      = (POOL_DEPTH > 2) ? $clog2(POOL_DEPTH) : 1;
    localparam int AGE_W      = IDX_W;
    localparam int CNT_W      = $clog2(POOL_DEPTH + 1);
    localparam int CMP_W      = (CNT_W > 8) ? CNT_W : 8;

    localparam int FUNC_W     = 2;
    localparam int ID_W       = 8;
    localparam int TRACK_W    = 16;
    localparam int QLIM_W     = 5;
    localparam int RCNT_W     = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [FUNC_W-1:0] FUNC_START  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SUBMIT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DONE   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LIMIT     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REQUESTER_COUNT = 1'b1;

    localparam logic [QLIM_W-1:0] QLIM_RESET = 5'd4;
    localparam logic [RCNT_W-1:0] RCNT_RESET = 8'd1;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [ID_W-1:0]    requester_id;
        logic [TRACK_W-1:0] track;
    } cmd_item_t;

    typedef struct packed {
        logic [ID_W-1:0]    served_id;
        logic [TRACK_W-1:0] served_track;
    } srv_item_t;

    typedef struct packed {
        logic             clear;
        logic             en;
        logic [IDX_W-1:0] idx;
        logic             entry_valid;
        logic [AGE_W-1:0] entry_age;
    } scan_ctl_t;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [AGE_W-1:0] age;
        srv_item_t        entry;
    } best_t;

endpackage

[design/sstf_disk_request_scheduler_top.sv]
// Shortest-seek-time-first request scheduler.
// Command channel (cmd_valid/cmd_stall/cmd): start, submit or done items.
// Service channel (srv_valid/srv_stall/srv): the request picked by nearest
// seek distance from the head, ties to the oldest pending request.
// Config channel (cfg_valid/cfg_ready): index 0 queue limit, 1 requester
// count; always ready, write only while the block is idle.
// An item that triggers no service is taken without raising cmd_stall. An
// item that triggers service holds cmd_stall through the scan (one pool
// memory read per entry), the compare tail and the update cycle for that
// item; the result is loaded into the output register in the update cycle.
// The pool memory has one read port, so the scan reads one entry at a time.
// The result sits in an output register; new commands are taken while it
// waits. If a new result is ready while srv_stall holds the old one, the
// block waits in its update cycle until the register frees.
// Reset empties the pool, puts the head at track 0, clears limit and active
// count and sets the config registers to 4 and 1. No clearing pass is needed.
`include "sstf_disk_request_scheduler_top_macros.svh"

module sstf_disk_request_scheduler_top
    import sstf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_stall,
    input  cmd_item_t             cmd,
    output logic                  srv_valid,
    input  logic                  srv_stall,
    output srv_item_t             srv,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_SERVE = 4'b1000
    } state_t;

    state_t                  state_reg, state_next;
    logic [QLIM_W-1:0]       queue_limit_reg;
    logic [RCNT_W-1:0]       requester_count_reg;
    logic [POOL_DEPTH-1:0]   valid_reg, valid_next;
    logic [AGE_W-1:0]        age_reg [POOL_DEPTH];
    logic [AGE_W-1:0]        age_next [POOL_DEPTH];
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        limit_reg, limit_next;
    logic [RCNT_W-1:0]       active_reg, active_next;
    logic [TRACK_W-1:0]      head_reg, head_next;
    logic [IDX_W-1:0]        scan_idx_reg, scan_idx_next;
    logic                    cmp_en_reg;
    logic [IDX_W-1:0]        cmp_idx_reg;
    logic                    srv_valid_reg, srv_valid_next;
    srv_item_t               srv_item_reg;

    logic                    accept;
    logic                    slot_free;
    logic                    out_load;
    logic                    free_found;
    logic [IDX_W-1:0]        free_idx;
    logic                    wr_en;
    logic                    scan_clear;
    logic [RCNT_W-1:0]       active_dec;
    logic [CNT_W-1:0]        limit_sat;
    scan_ctl_t               ctl;
    best_t                   best;
    srv_item_t               rd_data;

    assign accept    = cmd_valid && !cmd_stall;
    assign cmd_stall = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign slot_free = !srv_valid_reg || !srv_stall;
    assign out_load  = (state_reg == ST_SERVE) && slot_free;

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = POOL_DEPTH - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        if (CMP_W'(queue_limit_reg) > CMP_W'(POOL_DEPTH))
        begin
            limit_sat = CNT_W'(POOL_DEPTH);
        end
        else
        begin
            limit_sat = CNT_W'(queue_limit_reg);
        end
        active_dec = (active_reg == '0) ? '0 : active_reg - 1'b1;
    end

    always_comb
    begin
        state_next    = state_reg;
        valid_next    = valid_reg;
        age_next      = age_reg;
        count_next    = count_reg;
        limit_next    = limit_reg;
        active_next   = active_reg;
        head_next     = head_reg;
        scan_idx_next = scan_idx_reg;
        wr_en         = 1'b0;
        scan_clear    = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.func)
                        FUNC_START:
                        begin
                            limit_next  = limit_sat;
                            active_next = requester_count_reg;
                            head_next   = '0;
                        end
                        FUNC_SUBMIT:
                        begin
                            if ((count_reg < CNT_W'(POOL_DEPTH)) && free_found)
                            begin
                                wr_en                = 1'b1;
                                valid_next[free_idx] = 1'b1;
                                age_next[free_idx]   = AGE_W'(count_reg);
                                count_next           = count_reg + 1'b1;
                            end
                        end
                        FUNC_DONE:
                        begin
                            active_next = active_dec;
                            if ((CMP_W'(active_dec) < CMP_W'(limit_reg)) &&
                                (limit_reg != '0))
                            begin
                                limit_next = limit_reg - 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    if ((count_next != '0) && (count_next >= limit_next))
                    begin
                        state_next    = ST_SCAN;
                        scan_idx_next = '0;
                        scan_clear    = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                scan_idx_next = scan_idx_reg + 1'b1;
                if (scan_idx_reg == IDX_W'(POOL_DEPTH - 1))
                begin
                    scan_idx_next = '0;
                    state_next    = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_SERVE;
            end
            ST_SERVE:
            begin
                if (slot_free)
                begin
                    valid_next[best.idx] = 1'b0;
                    for (int i = 0; i < POOL_DEPTH; i++)
                    begin
                        if (valid_reg[i] && (age_reg[i] > best.age))
                        begin
                            age_next[i] = age_reg[i] - 1'b1;
                        end
                    end
                    count_next = count_reg - 1'b1;
                    head_next  = best.entry.served_track;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        srv_valid_next = srv_valid_reg;
        if (out_load)
        begin
            srv_valid_next = 1'b1;
        end
        else if (srv_valid_reg && !srv_stall)
        begin
            srv_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            queue_limit_reg     <= QLIM_RESET;
            requester_count_reg <= RCNT_RESET;
            valid_reg           <= '0;
            count_reg           <= '0;
            limit_reg           <= '0;
            active_reg          <= '0;
            head_reg            <= '0;
            scan_idx_reg        <= '0;
            cmp_en_reg          <= 1'b0;
            cmp_idx_reg         <= '0;
            srv_valid_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            count_reg     <= count_next;
            limit_reg     <= limit_next;
            active_reg    <= active_next;
            head_reg      <= head_next;
            scan_idx_reg  <= scan_idx_next;
            cmp_en_reg    <= (state_reg == ST_SCAN);
            cmp_idx_reg   <= scan_idx_reg;
            srv_valid_reg <= srv_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_QUEUE_LIMIT:     queue_limit_reg     <= cfg_data[QLIM_W-1:0];
                    CFG_REQUESTER_COUNT: requester_count_reg <= cfg_data[RCNT_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        age_reg <= age_next;
        if (out_load)
        begin
            srv_item_reg <= best.entry;
        end
    end

    assign ctl.clear       = scan_clear;
    assign ctl.en          = cmp_en_reg;
    assign ctl.idx         = cmp_idx_reg;
    assign ctl.entry_valid = valid_reg[cmp_idx_reg];
    assign ctl.entry_age   = age_reg[cmp_idx_reg];

    sstf_pool_ram u_pool_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (free_idx),
        .wr_data ({cmd.requester_id, cmd.track}),
        .rd_en   (state_reg == ST_SCAN),
        .rd_addr (scan_idx_reg),
        .rd_data (rd_data)
    );

    sstf_scan u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .rd_data (rd_data),
        .head    (head_reg),
        .best    (best)
    );

    assign srv_valid = srv_valid_reg;
    assign srv       = srv_item_reg;

    `SSTF_ASSERT_NOW(a_count_matches_valid, 1'b1, CNT_W'($countones(valid_reg)) == count_reg, "pool count differs from valid entries")
    `SSTF_ASSERT_NOW(a_serve_picks_valid, state_reg == ST_SERVE, valid_reg[best.idx], "serviced entry is not pending")
    `SSTF_ASSERT_NEXT(a_held_result_kept, srv_valid_reg && srv_stall, srv_valid_reg && $stable(srv_item_reg), "stalled result overwritten")
    `SSTF_ASSERT_NOW(a_limit_bound, 1'b1, limit_reg <= CNT_W'(POOL_DEPTH), "live limit beyond pool depth")

endmodule

[design/sstf_pool_ram.sv]
module sstf_pool_ram
    import sstf_pkg::*;
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  srv_item_t        wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output srv_item_t        rd_data
);

    srv_item_t mem [POOL_DEPTH];
    srv_item_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/sstf_scan.sv]
module sstf_scan
    import sstf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  scan_ctl_t          ctl,
    input  srv_item_t          rd_data,
    input  logic [TRACK_W-1:0] head,
    output best_t              best
);

    logic               found_reg;
    logic [TRACK_W-1:0] best_dist_reg;
    best_t              best_reg;
    logic [TRACK_W-1:0] seek_dist;
    logic               take;

    always_comb
    begin
        if (rd_data.served_track >= head)
        begin
            seek_dist = rd_data.served_track - head;
        end
        else
        begin
            seek_dist = head - rd_data.served_track;
        end
        take = ctl.en && ctl.entry_valid &&
               (!found_reg || (seek_dist < best_dist_reg) ||
                ((seek_dist == best_dist_reg) && (ctl.entry_age < best_reg.age)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (ctl.clear)
        begin
            found_reg <= 1'b0;
        end
        else if (take)
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_dist_reg <= seek_dist;
            best_reg.idx  <= ctl.idx;
            best_reg.age  <= ctl.entry_age;
            best_reg.entry <= rd_data;
        end
    end

    assign best = best_reg;

endmodule

[tb/sstf_service_checker.sv]
module sstf_service_checker
    import sstf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    input  logic                  cmd_stall,
    input  cmd_item_t             cmd,
    input  logic                  srv_valid,
    input  logic                  srv_stall,
    input  srv_item_t             srv,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    awaiting,
    output int                    served
);

    logic               slot_used  [POOL_DEPTH];
    logic [ID_W-1:0]    slot_id    [POOL_DEPTH];
    logic [TRACK_W-1:0] slot_track [POOL_DEPTH];
    logic [AGE_W-1:0]   slot_rank  [POOL_DEPTH];
    logic [CNT_W-1:0]   used_count;
    logic [TRACK_W-1:0] head_pos;
    logic [QLIM_W-1:0]  limit_now;
    logic [RCNT_W-1:0]  active_now;
    logic [QLIM_W-1:0]  qlim_reg;
    logic [RCNT_W-1:0]  rcnt_reg;
    srv_item_t          due_services[$];

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("%0t sstf mismatch: %s", $time, what);
    endtask

    task automatic advance_scheduler(input cmd_item_t c);
        int                 pick;
        logic [TRACK_W-1:0] seek_dist;
        logic [TRACK_W-1:0] best_dist;
        logic [AGE_W-1:0]   best_rank;
        srv_item_t          due;
        best_dist = '0;
        best_rank = '0;
        case (c.func)
            FUNC_START:
            begin
                limit_now  = (qlim_reg > POOL_DEPTH) ? QLIM_W'(POOL_DEPTH) : qlim_reg;
                active_now = rcnt_reg;
                head_pos   = '0;
            end
            FUNC_SUBMIT:
            begin
                pick = -1;
                for (int i = 0; i < POOL_DEPTH; i++)
                begin
                    if (pick < 0 && !slot_used[i])
                        pick = i;
                end
                if (pick >= 0 && used_count < POOL_DEPTH)
                begin
                    slot_used[pick]  = 1'b1;
                    slot_id[pick]    = c.requester_id;
                    slot_track[pick] = c.track;
                    slot_rank[pick]  = used_count[AGE_W-1:0];
                    used_count++;
                end
            end
            FUNC_DONE:
            begin
                if (active_now != 0)
                    active_now--;
                if (active_now < limit_now && limit_now != 0)
                    limit_now--;
            end
            default: ;
        endcase

        if (used_count != 0 && used_count >= limit_now)
        begin
            pick = -1;
            for (int i = 0; i < POOL_DEPTH; i++)
            begin
                if (slot_used[i])
                begin
                    seek_dist = (slot_track[i] >= head_pos) ? slot_track[i] - head_pos
                                                            : head_pos - slot_track[i];
                    if (pick < 0 || seek_dist < best_dist ||
                        (seek_dist == best_dist && slot_rank[i] < best_rank))
                    begin
                        pick      = i;
                        best_dist = seek_dist;
                        best_rank = slot_rank[i];
                    end
                end
            end
            slot_used[pick] = 1'b0;
            used_count--;
            for (int i = 0; i < POOL_DEPTH; i++)
            begin
                if (slot_used[i] && slot_rank[i] > best_rank)
                    slot_rank[i]--;
            end
            head_pos = slot_track[pick];
            due.served_id    = slot_id[pick];
            due.served_track = slot_track[pick];
            due_services.push_back(due);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        srv_item_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < POOL_DEPTH; i++)
            begin
                slot_used[i]  = 1'b0;
                slot_id[i]    = '0;
                slot_track[i] = '0;
                slot_rank[i]  = '0;
            end
            used_count = '0;
            head_pos   = '0;
            limit_now  = '0;
            active_now = '0;
            qlim_reg   = QLIM_RESET;
            rcnt_reg   = RCNT_RESET;
            due_services.delete();
            awaiting   = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_QUEUE_LIMIT:     qlim_reg = cfg_data[QLIM_W-1:0];
                    CFG_REQUESTER_COUNT: rcnt_reg = cfg_data[RCNT_W-1:0];
                    default: ;
                endcase
            end
            if (srv_valid && !srv_stall)
            begin
                if (due_services.size() == 0)
                    report_mismatch($sformatf("service id %0d track %0d with none due",
                                              srv.served_id, srv.served_track));
                else
                begin
                    want = due_services[0];
                    due_services.delete(0);
                    served++;
                    if (srv.served_id !== want.served_id)
                        report_mismatch($sformatf("served_id %0d, want %0d",
                                                  srv.served_id, want.served_id));
                    if (srv.served_track !== want.served_track)
                        report_mismatch($sformatf("served_track %0d, want %0d",
                                                  srv.served_track, want.served_track));
                end
            end
            if (cmd_valid && !cmd_stall)
                advance_scheduler(cmd);
            awaiting = due_services.size();
        end
    end

endmodule

[tb/testbench.sv]
module testbench;

    import sstf_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cmd_valid = 1'b0;
    cmd_item_t             cmd       = '0;
    logic                  srv_stall = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  cmd_stall;
    logic                  srv_valid;
    logic                  cfg_ready;
    srv_item_t             srv;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int items_sent    = 0;
    int mismatches;
    int awaiting;
    int served;

    sstf_disk_request_scheduler_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .srv_valid (srv_valid),
        .srv_stall (srv_stall),
        .srv       (srv),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sstf_service_checker service_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd        (cmd),
        .srv_valid  (srv_valid),
        .srv_stall  (srv_stall),
        .srv        (srv),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .awaiting   (awaiting),
        .served     (served)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
        srv_stall <= ($urandom_range(99) < recv_idle_pct);

    initial
    begin
        #3000000;
        $display("[sstf_disk_request_scheduler_top] ERROR");
        $finish;
    end

    function automatic cmd_item_t make_cmd(input logic [FUNC_W-1:0]  f,
                                           input logic [ID_W-1:0]    id,
                                           input logic [TRACK_W-1:0] trk);
        cmd_item_t c;
        c.func         = f;
        c.requester_id = id;
        c.track        = trk;
        return c;
    endfunction

    function automatic logic [TRACK_W-1:0] pick_track();
        int sel = $urandom_range(9);
        if (sel < 4)
            return TRACK_W'($urandom);
        if (sel < 7)
            return TRACK_W'($urandom_range(24));
        if (sel == 7)
            return '0;
        if (sel == 8)
            return '1;
        return TRACK_W'($urandom_range(65535, 65520));
    endfunction

    task automatic send_cmd(input cmd_item_t it);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= it;
        do
            @(posedge clk);
        while (cmd_stall);
        items_sent++;
    endtask

    task automatic drain();
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (awaiting != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_setting(input logic [CFG_DATA_W-1:0] qlim,
                               input logic [CFG_DATA_W-1:0] rcnt,
                               input int                    count);
        int roll;
        drain();
        write_cfg(CFG_QUEUE_LIMIT, qlim);
        write_cfg(CFG_REQUESTER_COUNT, rcnt);
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(99);
            if (n == count / 2)
                drain();
            if (n == 0 || roll < 5)
                send_cmd(make_cmd(FUNC_START, ID_W'($urandom), TRACK_W'($urandom)));
            else if (roll < 70)
                send_cmd(make_cmd(FUNC_SUBMIT, ID_W'($urandom), pick_track()));
            else if (roll < 96)
                send_cmd(make_cmd(FUNC_DONE, ID_W'($urandom), TRACK_W'($urandom)));
            else
                send_cmd(make_cmd(FUNC_UNUSED, ID_W'($urandom), TRACK_W'($urandom)));
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 19;
        recv_idle_pct = 51;

        send_cmd(make_cmd(FUNC_SUBMIT, 8'h00, 16'h0000));
        send_cmd(make_cmd(FUNC_SUBMIT, 8'hFF, 16'hFFFF));
        send_cmd(make_cmd(FUNC_DONE, 8'hFF, 16'hFFFF));
        send_cmd(make_cmd(FUNC_UNUSED, 8'h5A, 16'hA5A5));
        send_cmd(make_cmd(FUNC_START, 8'h00, 16'h0000));
        send_cmd(make_cmd(FUNC_SUBMIT, 8'd1, 16'd100));
        send_cmd(make_cmd(FUNC_SUBMIT, 8'd2, 16'd200));
        send_cmd(make_cmd(FUNC_SUBMIT, 8'd3, 16'd300));
        send_cmd(make_cmd(FUNC_SUBMIT, 8'd4, 16'd100));
        send_cmd(make_cmd(FUNC_SUBMIT, 8'd5, 16'd50));
        send_cmd(make_cmd(FUNC_SUBMIT, 8'd6, 16'd150));
        send_cmd(make_cmd(FUNC_UNUSED, 8'hA5, 16'h5A5A));
        send_cmd(make_cmd(FUNC_DONE, 8'h00, 16'h0000));
        send_cmd(make_cmd(FUNC_DONE, 8'h00, 16'h0000));
        send_cmd(make_cmd(FUNC_DONE, 8'h00, 16'h0000));
        send_cmd(make_cmd(FUNC_DONE, 8'h00, 16'h0000));
        send_cmd(make_cmd(FUNC_SUBMIT, 8'hAA, 16'hFFFF));
        send_cmd(make_cmd(FUNC_SUBMIT, 8'h55, 16'h5555));

        run_setting(8'd16, 8'd255, 70);
        run_setting(8'd1, 8'd1, 60);

        send_idle_pct = 51;
        recv_idle_pct = 19;
        run_setting(8'd31, 8'd3, 60);
        run_setting(8'd8, 8'd20, 60);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_setting(CFG_DATA_W'($urandom_range(16, 1)), CFG_DATA_W'($urandom_range(255, 1)), 60);
        run_setting(8'd2, 8'd1, 60);

        drain();
        $display("Covered %0d commands and %0d checked services over six register settings,",
                 items_sent, served);
        $display("with sender and receiver stalls mixed both ways and a stall-free stretch.");
        if (mismatches == 0)
            $display("[sstf_disk_request_scheduler_top] OK");
        else
            $display("[sstf_disk_request_scheduler_top] ERROR");
        $finish;
    end

endmodule
